FILE: rtl/srpf_pkg.sv
// Shared types, constants and helpers of the solar pressure force block.
package srpf_pkg;

   // Wide working word of the shared arithmetic unit
   localparam int W_BIG = 160;
   // Quotient and square root width
   localparam int QW = 49;
   // Count width for QW iterations
   localparam int CNT_W = 6;
   // Width of the squared distance
   localparam int SW = 98;
   // Width of one stored vector component
   localparam int VW = 48;
   // Width of a separation component
   localparam int DW = 49;
   // Width of an exact direction dot product
   localparam int DOT_W = 67;

   // Four times flux * AU^2 / c, in newtons
   localparam logic [58:0] SRP_K4 = 59'd409840675920000000;
   // AU squared in square metres
   localparam logic [74:0] AU_SQ = 75'd22379522915879548300249;

   // Input word kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_USE_CANNON = 2'd0;
   localparam logic [1:0] CSR_COEFF = 2'd1;
   localparam logic [1:0] CSR_AREA = 2'd2;
   localparam logic [1:0] CSR_IN_USE = 2'd3;

   typedef enum logic [1:0] {
      MDU_MUL,
      MDU_DIV,
      MDU_SQRT
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_cmd_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } mdu_sts_type;

   // One table entry: direction packed x:y:z, force at 1 AU, torque
   typedef struct packed {
      logic [VW-1:0] tq_z;
      logic [VW-1:0] tq_y;
      logic [VW-1:0] tq_x;
      logic [VW-1:0] fc_z;
      logic [VW-1:0] fc_y;
      logic [VW-1:0] fc_x;
      logic [VW-1:0] dir;
   } tbl_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_RT_GO,
      ST_RT_WAIT,
      ST_DEN_GO,
      ST_DEN_WAIT,
      ST_CK_GO,
      ST_CK_WAIT,
      ST_NUM_GO,
      ST_NUM_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_WALK_RD,
      ST_WALK_DOT,
      ST_WALK_CMP,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_DONE
   } state_type;

   // Signed 48-bit result from a quotient magnitude, saturated
   function automatic logic [VW-1:0] sat_force(input logic neg, input logic [QW-1:0] q,
                                               input logic ovf);
      logic [QW-1:0] cap;
      logic [QW-1:0] m;
      cap = neg ? {2'b01, {(QW-2){1'b0}}} : {2'b00, {(QW-2){1'b1}}};
      m = (ovf || (q > cap)) ? cap : q;
      return neg ? VW'(QW'(0) - m) : VW'(m);
   endfunction

endpackage

FILE: rtl/solar_pressure_force.sv
// Solar radiation pressure force and torque: cannonball formula or table lookup.
// A load word writes one table entry and gives no result.
// A compute word runs the shared multiply/divide/root unit, one bit per cycle: |s|^2,
// root, |s|^3, coefficient, then multiply and divide per axis, stopping after |s|^2
// when the sun is coincident; lookup mode does a table walk over the searched entries
// and a fetch in place of root, |s|^3 and coefficient, and stops there if coincident.
// Synchronous reset returns control and configuration to defaults; table contents stay undefined.
module solar_pressure_force #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
   // vec_c_x, vec_c_y, vec_c_z
   input  logic [439:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, torque_x, torque_y, torque_z, entry_used
   output logic [295:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import srpf_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KW = $clog2(TABLE_DEPTH + 1);

   // Input fields
   logic [5:0]           in_index;
   logic signed [VW-1:0] in_a [3];
   logic signed [VW-1:0] in_b [3];
   logic [VW-1:0]        in_c [3];

   assign in_index = req_tdata[5:0];
   assign in_a[0] = req_tdata[53:6];
   assign in_a[1] = req_tdata[101:54];
   assign in_a[2] = req_tdata[149:102];
   assign in_b[0] = req_tdata[197:150];
   assign in_b[1] = req_tdata[245:198];
   assign in_b[2] = req_tdata[293:246];
   assign in_c[0] = req_tdata[341:294];
   assign in_c[1] = req_tdata[389:342];
   assign in_c[2] = req_tdata[437:390];

   state_type state_ff, state_in;

   // Configuration
   logic        cannon_ff, cannon_in;
   logic [14:0] coeff_ff, coeff_in;
   logic [23:0] area_ff, area_in;
   logic [6:0]  inuse_ff, inuse_in;

   // Working registers
   logic                    mode_ff, mode_in;
   logic [1:0]              ax_ff, ax_in;
   logic signed [DW-1:0]    s_ff [3];
   logic signed [DW-1:0]    s_in [3];
   logic [SW-1:0]           ssum_ff, ssum_in;
   logic [QW-1:0]           root_ff, root_in;
   logic [W_BIG-1:0]        den_ff, den_in;
   logic [W_BIG-1:0]        ck_ff, ck_in;
   logic [W_BIG-1:0]        num_ff, num_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [AW-1:0]           best_ff, best_in;
   logic signed [DOT_W-1:0] bdot_ff, bdot_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [VW-1:0]           f_ff [3];
   logic [VW-1:0]           f_in [3];
   logic [VW-1:0]           fo_ff [3];
   logic [VW-1:0]           fo_in [3];
   logic [VW-1:0]           to_ff [3];
   logic [VW-1:0]           to_in [3];
   logic [AW-1:0]           eu_ff, eu_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rfo_ff [3];
   logic [VW-1:0] rfo_in [3];
   logic [VW-1:0] rto_ff [3];
   logic [VW-1:0] rto_in [3];
   logic [5:0]    reu_ff, reu_in;

   // Arithmetic unit and table
   mdu_cmd_type      mdu_cmd;
   mdu_sts_type      mdu_sts;
   logic [W_BIG-1:0] mdu_opa;
   logic [W_BIG-1:0] mdu_opb;
   logic [W_BIG-1:0] mdu_addend;
   logic [W_BIG-1:0] mdu_result;

   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   tbl_entry_type tbl_wdata;
   logic          tbl_re;
   logic [AW-1:0] tbl_raddr;
   tbl_entry_type tbl_rdata;

   // Helpers
   logic                    req_fire;
   logic                    out_go;
   logic [KW-1:0]           lim;
   logic [DW-1:0]           s_mag;
   logic [VW-1:0]           f_mag;
   logic                    neg;
   logic [38:0]             coeff_area;
   logic signed [15:0]      dir_x, dir_y, dir_z;
   logic signed [DOT_W-1:0] dot;

   assign req_fire = req_tvalid && req_tready;
   assign out_go = !rsp_valid_ff || rsp_tready;
   assign lim = (32'(inuse_ff) < TABLE_DEPTH) ? KW'(inuse_ff) : KW'(TABLE_DEPTH);
   assign coeff_area = 39'(coeff_ff) * 39'(area_ff);

   // Per-axis magnitudes and sign of the result
   always_comb begin
      s_mag = s_ff[ax_ff][DW-1] ? DW'(-s_ff[ax_ff]) : DW'(s_ff[ax_ff]);
      f_mag = f_ff[ax_ff][VW-1] ? VW'(-f_ff[ax_ff]) : f_ff[ax_ff];
      neg = mode_ff ? (s_ff[ax_ff] > DW'(0)) : f_ff[ax_ff][VW-1];
   end

   // Exact dot product of a stored direction with the separation
   always_comb begin
      logic signed [DOT_W-1:0] p0, p1, p2;
      dir_x = $signed(tbl_rdata.dir[47:32]);
      dir_y = $signed(tbl_rdata.dir[31:16]);
      dir_z = $signed(tbl_rdata.dir[15:0]);
      p0 = dir_x * s_ff[0];
      p1 = dir_y * s_ff[1];
      p2 = dir_z * s_ff[2];
      dot = p0 + p1 + p2;
   end

   // Table write on a load word
   always_comb begin
      tbl_we = req_fire && (req_tuser == KIND_LOAD) && (32'(in_index) < TABLE_DEPTH);
      tbl_waddr = AW'(in_index);
      tbl_wdata.dir = {in_a[0][15:0], in_a[1][15:0], in_a[2][15:0]};
      tbl_wdata.fc_x = in_b[0];
      tbl_wdata.fc_y = in_b[1];
      tbl_wdata.fc_z = in_b[2];
      tbl_wdata.tq_x = in_c[0];
      tbl_wdata.tq_y = in_c[1];
      tbl_wdata.tq_z = in_c[2];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_COMPUTE)) begin
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (mdu_sts.done) begin
               if (ax_ff != 2'd2) begin
                  state_in = ST_SQ_GO;
               end else if (!mode_ff) begin
                  state_in = ST_WALK_RD;
               end else if (mdu_result == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RT_GO;
               end
            end
         end
         ST_RT_GO: state_in = ST_RT_WAIT;
         ST_RT_WAIT: if (mdu_sts.done) state_in = ST_DEN_GO;
         ST_DEN_GO: state_in = ST_DEN_WAIT;
         ST_DEN_WAIT: if (mdu_sts.done) state_in = ST_CK_GO;
         ST_CK_GO: state_in = ST_CK_WAIT;
         ST_CK_WAIT: if (mdu_sts.done) state_in = ST_NUM_GO;
         ST_NUM_GO: state_in = ST_NUM_WAIT;
         ST_NUM_WAIT: if (mdu_sts.done) state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (mdu_sts.done) begin
               state_in = (ax_ff == 2'd2) ? ST_DONE : ST_NUM_GO;
            end
         end
         ST_WALK_RD: state_in = (k_ff < lim) ? ST_WALK_DOT : ST_FETCH;
         ST_WALK_DOT: state_in = ST_WALK_CMP;
         ST_WALK_CMP: state_in = ST_WALK_RD;
         ST_FETCH: state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = (ssum_ff == '0) ? ST_DONE : ST_NUM_GO;
         ST_DONE: if (out_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake, unit commands, table reads
   always_comb begin
      req_tready = 1'b0;
      mdu_cmd.start = 1'b0;
      mdu_cmd.op = MDU_MUL;
      mdu_opa = '0;
      mdu_opb = '0;
      mdu_addend = '0;
      tbl_re = 1'b0;
      tbl_raddr = k_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SQ_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_opa = W_BIG'(s_mag);
            mdu_opb = W_BIG'(s_mag);
            mdu_addend = W_BIG'(ssum_ff);
         end
         ST_RT_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_cmd.op = MDU_SQRT;
            mdu_opa = W_BIG'(ssum_ff);
         end
         ST_DEN_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_opa = W_BIG'(ssum_ff);
            mdu_opb = W_BIG'(root_ff);
         end
         ST_CK_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_opa = W_BIG'(SRP_K4);
            mdu_opb = W_BIG'(coeff_area);
         end
         ST_NUM_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_opa = mode_ff ? ck_ff : W_BIG'(AU_SQ);
            mdu_opb = mode_ff ? W_BIG'(s_mag) : W_BIG'(f_mag);
         end
         ST_DIV_GO: begin
            mdu_cmd.start = 1'b1;
            mdu_cmd.op = MDU_DIV;
            mdu_opa = num_ff;
            mdu_opb = mode_ff ? den_ff : W_BIG'(ssum_ff);
         end
         ST_WALK_RD: tbl_re = (k_ff < lim);
         ST_FETCH: begin
            tbl_re = 1'b1;
            tbl_raddr = best_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath and configuration next values
   always_comb begin
      cannon_in = cannon_ff;
      coeff_in = coeff_ff;
      area_in = area_ff;
      inuse_in = inuse_ff;
      mode_in = mode_ff;
      ax_in = ax_ff;
      s_in = s_ff;
      ssum_in = ssum_ff;
      root_in = root_ff;
      den_in = den_ff;
      ck_in = ck_ff;
      num_in = num_ff;
      k_in = k_ff;
      best_in = best_ff;
      bdot_in = bdot_ff;
      dot_in = dot_ff;
      f_in = f_ff;
      fo_in = fo_ff;
      to_in = to_ff;
      eu_in = eu_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rfo_in = rfo_ff;
      rto_in = rto_ff;
      reu_in = reu_ff;

      // Take a configuration write
      if (csr_we) begin
         unique case (csr_index)
            CSR_USE_CANNON: cannon_in = csr_wdata[0];
            CSR_COEFF: coeff_in = csr_wdata[14:0];
            CSR_AREA: area_in = csr_wdata;
            CSR_IN_USE: inuse_in = csr_wdata[6:0];
            default: cannon_in = cannon_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_COMPUTE)) begin
               for (int i = 0; i < 3; i++) begin
                  s_in[i] = DW'(in_a[i]) - DW'(in_b[i]);
                  fo_in[i] = '0;
                  to_in[i] = '0;
               end
               mode_in = cannon_ff;
               ax_in = '0;
               ssum_in = '0;
               eu_in = '0;
               k_in = '0;
               best_in = '0;
               bdot_in = '0;
            end
         end
         ST_SQ_WAIT: begin
            if (mdu_sts.done) begin
               ssum_in = mdu_result[SW-1:0];
               ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end
         end
         ST_RT_WAIT: if (mdu_sts.done) root_in = mdu_result[QW-1:0];
         ST_DEN_WAIT: if (mdu_sts.done) den_in = mdu_result;
         ST_CK_WAIT: if (mdu_sts.done) ck_in = mdu_result;
         ST_NUM_WAIT: if (mdu_sts.done) num_in = mdu_result;
         ST_DIV_WAIT: begin
            if (mdu_sts.done) begin
               fo_in[ax_ff] = sat_force(neg, mdu_result[QW-1:0], mdu_sts.ovf);
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_WALK_DOT: dot_in = dot;
         ST_WALK_CMP: begin
            // Keep the first entry with the strictly largest dot product, entry 0 if none is positive
            if (dot_ff > bdot_ff) begin
               best_in = k_ff[AW-1:0];
               bdot_in = dot_ff;
            end
            k_in = k_ff + 1'b1;
         end
         ST_FETCH_WAIT: begin
            f_in[0] = tbl_rdata.fc_x;
            f_in[1] = tbl_rdata.fc_y;
            f_in[2] = tbl_rdata.fc_z;
            to_in[0] = tbl_rdata.tq_x;
            to_in[1] = tbl_rdata.tq_y;
            to_in[2] = tbl_rdata.tq_z;
            eu_in = best_ff;
            ax_in = '0;
         end
         ST_DONE: begin
            // Hand the result to the output register
            if (out_go) begin
               rsp_valid_in = 1'b1;
               rfo_in = fo_ff;
               rto_in = to_ff;
               reu_in = 6'(eu_ff);
            end
         end
         default: begin
            ax_in = ax_ff;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cannon_ff <= 1'b1;
         coeff_ff <= 15'd19661;
         area_ff <= '0;
         inuse_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cannon_ff <= cannon_in;
         coeff_ff <= coeff_in;
         area_ff <= area_in;
         inuse_ff <= inuse_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      ax_ff <= ax_in;
      s_ff <= s_in;
      ssum_ff <= ssum_in;
      root_ff <= root_in;
      den_ff <= den_in;
      ck_ff <= ck_in;
      num_ff <= num_in;
      k_ff <= k_in;
      best_ff <= best_in;
      bdot_ff <= bdot_in;
      dot_ff <= dot_in;
      f_ff <= f_in;
      fo_ff <= fo_in;
      to_ff <= to_in;
      eu_ff <= eu_in;
      rfo_ff <= rfo_in;
      rto_ff <= rto_in;
      reu_ff <= reu_in;
   end

   srpf_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mdu_cmd),
      .opa    (mdu_opa),
      .opb    (mdu_opb),
      .addend (mdu_addend),
      .sts    (mdu_sts),
      .result (mdu_result)
   );

   srpf_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, reu_ff, rto_ff[2], rto_ff[1], rto_ff[0],
                       rfo_ff[2], rfo_ff[1], rfo_ff[0]};

endmodule

FILE: rtl/srpf_table.sv
// Reference table memory: one write port, one registered read port.
module srpf_table #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  srpf_pkg::tbl_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output srpf_pkg::tbl_entry_type rd_data
);
   import srpf_pkg::*;

   tbl_entry_type tbl_mem [DEPTH];
   tbl_entry_type rd_data_ff;

   // Write one entry per load word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/srpf_mdu.sv
// Shared sequential unit: shift-add multiply, restoring divide, digit square root.
module srpf_mdu (
   input  logic                        clock,
   input  logic                        reset,
   input  srpf_pkg::mdu_cmd_type       cmd,
   input  logic [srpf_pkg::W_BIG-1:0]  opa,
   input  logic [srpf_pkg::W_BIG-1:0]  opb,
   input  logic [srpf_pkg::W_BIG-1:0]  addend,
   output srpf_pkg::mdu_sts_type       sts,
   output logic [srpf_pkg::W_BIG-1:0]  result
);
   import srpf_pkg::*;

   logic [W_BIG-1:0] a_ff, a_in;
   logic [W_BIG-1:0] b_ff, b_in;
   logic [W_BIG:0]   acc_ff, acc_in;
   logic [W_BIG-1:0] d_ff, d_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mdu_op_type       op_ff, op_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;

   logic [W_BIG:0] t_div;
   logic [W_BIG:0] t_sq;
   logic [W_BIG:0] trial_sq;
   logic           finish;

   // Trial values of one divide or root step
   always_comb begin
      t_div = {acc_ff[W_BIG-1:0], b_ff[QW-1]};
      t_sq = {acc_ff[W_BIG-2:0], b_ff[2*QW-1 -: 2]};
      trial_sq = (W_BIG+1)'({q_ff, 2'b01});
      finish = (op_ff == MDU_MUL) ? (b_ff == '0) : (cnt_ff == '0);
   end

   // Load on start, then one bit or one digit per cycle
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      d_in = d_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      run_in = run_ff;
      done_in = 1'b0;
      ovf_in = ovf_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         run_in = 1'b1;
         q_in = '0;
         cnt_in = CNT_W'(QW);
         ovf_in = 1'b0;
         a_in = opa;
         b_in = (cmd.op == MDU_MUL) ? opb : opa;
         d_in = opb;
         unique case (cmd.op)
            MDU_MUL: begin
               acc_in = {1'b0, addend};
            end
            MDU_DIV: begin
               acc_in = {1'b0, opa >> QW};
               ovf_in = (opa >> QW) >= opb;
            end
            MDU_SQRT: begin
               acc_in = '0;
            end
            default: begin
               acc_in = '0;
            end
         endcase
      end else if (run_ff) begin
         if (finish) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            unique case (op_ff)
               MDU_MUL: begin
                  if (b_ff[0]) begin
                     acc_in = acc_ff + {1'b0, a_ff};
                  end
                  a_in = a_ff << 1;
                  b_in = b_ff >> 1;
               end
               MDU_DIV: begin
                  b_in = b_ff << 1;
                  if (t_div >= {1'b0, d_ff}) begin
                     acc_in = t_div - {1'b0, d_ff};
                     q_in = {q_ff[QW-2:0], 1'b1};
                  end else begin
                     acc_in = t_div;
                     q_in = {q_ff[QW-2:0], 1'b0};
                  end
               end
               MDU_SQRT: begin
                  b_in = b_ff << 2;
                  if (t_sq >= trial_sq) begin
                     acc_in = t_sq - trial_sq;
                     q_in = {q_ff[QW-2:0], 1'b1};
                  end else begin
                     acc_in = t_sq;
                     q_in = {q_ff[QW-2:0], 1'b0};
                  end
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= MDU_MUL;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         op_ff <= op_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      d_ff <= d_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign sts.done = done_ff;
   assign sts.ovf = ovf_ff;
   assign result = (op_ff == MDU_MUL) ? acc_ff[W_BIG-1:0] : W_BIG'(q_ff);

endmodule

FILE: tb/sv/tb_solar_pressure_force.sv
// Self-checking testbench for the solar pressure force block: directed and random stream traffic.
module tb_solar_pressure_force;
   timeunit 1ns;
   timeprecision 1ps;
   import srpf_pkg::*;

   localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;
   localparam logic [47:0] AU_M = 48'd149597870693;
   localparam logic [255:0] FOUR_K = 256'd409840675920000000;
   localparam logic [255:0] AU_SQUARED = 256'd22379522915879548300249;
   localparam int DRAIN_CYCLES = 1000;

   typedef struct packed {
      logic         kind;
      logic [439:0] data;
   } req_word_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [439:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [295:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;

   // model copy of configuration and table (whole load word per entry)
   logic         cfg_cannon = 1'b1;
   logic [14:0]  cfg_coeff = 15'd19661;
   logic [23:0]  cfg_area = '0;
   logic [6:0]   cfg_in_use = '0;
   logic [439:0] entry_tab [64];

   req_word_t    pending_words [$];
   logic [295:0] expected_rsp [$];
   bit           req_fire = 0;
   bit           failed = 0;
   int           idle_pct = 35;

   solar_pressure_force dut (.*);

   always #5 clock = ~clock;

   // saturate a quotient magnitude to a signed 48-bit field
   function automatic logic [47:0] sat48(input logic neg, input logic [255:0] q);
      logic [255:0] m;
      if (neg) begin
         m = (q > 256'h8000_0000_0000) ? 256'h8000_0000_0000 : q;
         return 48'(256'd0 - m);
      end
      m = (q > 256'h7FFF_FFFF_FFFF) ? 256'h7FFF_FFFF_FFFF : q;
      return m[47:0];
   endfunction

   // expected force/torque/entry word for a compute word
   function automatic logic [295:0] srp_response(input logic [439:0] d);
      logic signed [48:0] s [3];
      logic [255:0] mag [3];
      logic [255:0] ssq, root, cand, den, coef, q, fmag;
      logic signed [79:0] dot, best_dot, dv;
      logic [47:0] fo [3];
      logic [47:0] to [3];
      logic [47:0] fv;
      logic [5:0] best;
      int lim;
      ssq = '0;
      for (int i = 0; i < 3; i++) begin
         s[i] = $signed({d[6+48*i+47], d[6+48*i +: 48]})
              - $signed({d[150+48*i+47], d[150+48*i +: 48]});
         mag[i] = s[i] < 0 ? 256'(-s[i]) : 256'(s[i]);
         ssq = ssq + mag[i] * mag[i];
         fo[i] = '0;
         to[i] = '0;
      end
      best = '0;
      if (cfg_cannon) begin
         if (ssq != 0) begin
            root = '0;
            for (int b = 50; b >= 0; b--) begin
               cand = root | (256'd1 << b);
               if (cand * cand <= ssq) root = cand;
            end
            den = ssq * root;
            coef = 256'(cfg_coeff) * 256'(cfg_area) * FOUR_K;
            for (int i = 0; i < 3; i++) begin
               q = coef * mag[i] / den;
               fo[i] = sat48(s[i] > 0, q);
            end
         end
      end else begin
         lim = cfg_in_use > 64 ? 64 : int'(cfg_in_use);
         best_dot = '0;
         for (int k = 0; k < lim; k++) begin
            dot = '0;
            for (int i = 0; i < 3; i++) begin
               dv = 80'($signed(entry_tab[k][6+48*i +: 16]));
               dot = dot + dv * 80'(s[i]);
            end
            if (dot > best_dot) begin
               best_dot = dot;
               best = 6'(k);
            end
         end
         for (int i = 0; i < 3; i++) begin
            fv = entry_tab[best][150+48*i +: 48];
            fmag = fv[47] ? 256'(-$signed(fv)) : 256'(fv);
            if (ssq != 0) fo[i] = sat48(fv[47], fmag * AU_SQUARED / ssq);
            to[i] = entry_tab[best][294+48*i +: 48];
         end
      end
      return {2'b00, best, to[2], to[1], to[0], fo[2], fo[1], fo[0]};
   endfunction

   // random coordinate, weighted toward sizes that matter here
   function automatic logic [47:0] rnd_coord();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return r[47:0];
         1: return {{36{r[11]}}, r[11:0]};
         2: return r[40] ? AU_M + 48'(r[29:0]) : 48'(0) - AU_M - 48'(r[29:0]);
         3: return r[0] ? POS_MAX : POS_MIN;
         default: return {{16{r[31]}}, r[31:0]};
      endcase
   endfunction

   function automatic req_word_t mk_word(input logic kind, input logic [5:0] idx,
                                         input logic [431:0] vecs);
      return '{kind: kind, data: {2'b00, vecs, idx}};
   endfunction

   // load word: direction, force at 1 AU, torque
   function automatic req_word_t rnd_load(input logic [5:0] idx);
      logic [431:0] v;
      logic [63:0] r;
      for (int i = 0; i < 9; i++) begin
         r = {$urandom, $urandom};
         if (i < 3)
            v[48*i +: 48] = ($urandom_range(9) == 0) ? r[47:0] : {{32{r[15]}}, r[15:0]};
         else if (i < 6)
            v[48*i +: 48] = ($urandom_range(3) == 0) ? r[47:0] : {{20{r[27]}}, r[27:0]};
         else
            v[48*i +: 48] = r[47:0];
      end
      return mk_word(KIND_LOAD, idx, v);
   endfunction

   // compute word: spacecraft and sun positions, ignored c vector random
   function automatic req_word_t rnd_compute();
      logic [431:0] v;
      for (int i = 0; i < 9; i++)
         v[48*i +: 48] = ($urandom_range(1) == 1) ? rnd_coord() : 48'({$urandom, $urandom});
      case ($urandom_range(19))
         0: v[287:144] = v[143:0];
         1, 2, 3, 4: for (int i = 3; i < 6; i++) v[48*i +: 48] = 48'($signed($urandom_range(2000)) - 1000);
         default: ;
      endcase
      return mk_word(KIND_COMPUTE, 6'($urandom), v);
   endfunction

   function automatic req_word_t pos_pair(input logic [47:0] ax, ay, az, bx, by, bz);
      return mk_word(KIND_COMPUTE, '0, {144'd0, bz, by, bx, az, ay, ax});
   endfunction

   // write all four registers back to back and mirror them
   task automatic set_config(input logic cannon, input logic [14:0] coeff,
                             input logic [23:0] area, input logic [6:0] in_use);
      csr_we <= 1'b1;
      csr_index <= CSR_USE_CANNON;
      csr_wdata <= 24'(cannon);
      @(negedge clock);
      csr_index <= CSR_COEFF;
      csr_wdata <= 24'(coeff);
      @(negedge clock);
      csr_index <= CSR_AREA;
      csr_wdata <= area;
      @(negedge clock);
      csr_index <= CSR_IN_USE;
      csr_wdata <= 24'(in_use);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_cannon = cannon;
      cfg_coeff = coeff;
      cfg_area = area;
      cfg_in_use = in_use;
      @(negedge clock);
   endtask

   // wait until every word is sent and every result checked, then let loads settle
   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver: present words from the queue, random gaps on both sides
   always @(negedge clock) begin : driver
      req_word_t w;
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               w = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= w.data;
               req_tuser <= w.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         req_fire = 0;
      end
   end

   // monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin : monitor
      string fname [6] = '{"force_x", "force_y", "force_z", "torque_x", "torque_y", "torque_z"};
      logic [295:0] exp_w;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fire = 1;
            if (req_tuser == KIND_LOAD) entry_tab[req_tdata[5:0]] = req_tdata;
            else expected_rsp.push_back(srp_response(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               failed = 1;
            end else begin
               exp_w = expected_rsp.pop_front();
               for (int f = 0; f < 6; f++)
                  if (rsp_tdata[48*f +: 48] !== exp_w[48*f +: 48]) begin
                     $error("%s expected %h got %h", fname[f], exp_w[48*f +: 48],
                            rsp_tdata[48*f +: 48]);
                     failed = 1;
                  end
               if (rsp_tdata[293:288] !== exp_w[293:288]) begin
                  $error("entry_used expected %0d got %0d", exp_w[293:288], rsp_tdata[293:288]);
                  failed = 1;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [431:0] v;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: cannonball with zero area gives zero force
      for (int i = 0; i < 3; i++) pending_words.push_back(rnd_compute());
      // fill every entry so no lookup reads an unwritten one
      v = {POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, 48'h0000_0000_4000,
           48'h0000_0000_8000, 48'h0000_0000_7FFF};
      pending_words.push_back(mk_word(KIND_LOAD, 6'd0, v));
      for (int k = 1; k < 64; k++) pending_words.push_back(rnd_load(6'(k)));
      // wide direction: only low 16 bits count
      pending_words.push_back(mk_word(KIND_LOAD, 6'd63, {{3{POS_MAX}}, {3{48'd1 << 30}},
                                      48'hFFFF_FFFF_0001, 48'h1234_5678_C000, 48'hABCD_0000_4000}));
      drain();

      // lookup, directed: coincident sun, extreme separations, small distance
      set_config(1'b0, 15'd19661, 24'd0, 7'd64);
      pending_words.push_back(pos_pair('0, '0, '0, '0, '0, '0));
      pending_words.push_back(pos_pair(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
      pending_words.push_back(pos_pair(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
      pending_words.push_back(pos_pair(AU_M, '0, '0, '0, '0, '0));
      pending_words.push_back(pos_pair('0, '0, 48'd1, '0, '0, '0));
      pending_words.push_back(pos_pair(48'd5, 48'd5, 48'd5, 48'd5, 48'd5, 48'd5));
      drain();

      // cannonball at full coefficient and area
      set_config(1'b1, 15'h7FFF, 24'hFF_FFFF, 7'd0);
      pending_words.push_back(pos_pair('0, '0, '0, '0, '0, '0));
      pending_words.push_back(pos_pair(48'd1, '0, '0, '0, '0, '0));
      pending_words.push_back(pos_pair('0, POS_MIN, '0, '0, 48'd1, '0));
      pending_words.push_back(pos_pair(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
      pending_words.push_back(pos_pair(AU_M, AU_M, '0, '0, '0, AU_M));
      drain();

      // lookup over one entry, then none
      set_config(1'b0, 15'd0, 24'd0, 7'd1);
      pending_words.push_back(pos_pair(AU_M, 48'd7, '0, '0, '0, '0));
      drain();
      set_config(1'b0, 15'd0, 24'd0, 7'd0);
      pending_words.push_back(pos_pair(48'd3, '0, '0, '0, '0, '0));
      drain();

      // random phases, one of them without idling
      for (int p = 0; p < 12; p++) begin
         idle_pct = (p == 5) ? 0 : 35;
         set_config(1'(p[0] ^ $urandom_range(1)),
                    ($urandom_range(4) == 0) ? 15'h7FFF : 15'($urandom),
                    ($urandom_range(4) == 0) ? 24'hFF_FFFF
                    : ($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(1 << 20))),
                    ($urandom_range(5) == 0) ? 7'd64 : 7'($urandom_range(12)));
         for (int n = 0; n < 130; n++)
            pending_words.push_back(($urandom_range(99) < 35) ? rnd_load(6'($urandom))
                                                              : rnd_compute());
         drain();
      end

      if (!failed) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end

endmodule
